/* rtl/lkcc_pkg.sv */
// Package for the keyed LRU configuration cache.
// Holds the transaction payload types and the controller/datapath link types.
// No dependencies.
package lkcc_pkg;

   localparam int KEY_W      = 72;
   localparam int SLOT_OUT_W = 3;

   typedef struct packed {
      logic [15:0] src_width;
      logic [15:0] src_height;
      logic [15:0] dst_width;
      logic [15:0] dst_height;
      logic [3:0]  horiz_taps;
      logic [3:0]  vert_taps;
   } req_type;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic                  slot_valid;
      logic                  evicted;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic reject;
      logic scan;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic enable;
      logic last_addr;
   } status_type;

endpackage

/* rtl/lkcc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lkcc_ctrl.sv */
// Controller of the keyed LRU cache: sequences the slot scan and the update.
// Depends on lkcc_pkg.
module lkcc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  lkcc_pkg::status_type status,
   output lkcc_pkg::cmd_type    cmd
);
   import lkcc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && status.enable) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.last_addr) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT:   state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign cmd.load   = (state_ff == ST_IDLE) && start;
   assign cmd.reject = (state_ff == ST_IDLE) && start && !status.enable;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.commit = (state_ff == ST_COMMIT);

endmodule

/* rtl/lkcc_dpath.sv */
// Datapath of the keyed LRU cache: key RAM, used bits, recency ranks, scan trackers.
// Depends on lkcc_pkg and lkcc_ram.
module lkcc_dpath #(
   parameter int CACHE_SLOTS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lkcc_pkg::req_type    req_data,
   input  logic                 csr_valid,
   input  logic                 csr_data,
   input  lkcc_pkg::cmd_type    cmd,
   output lkcc_pkg::status_type status,
   output logic                 rsp_valid,
   output lkcc_pkg::rsp_type    rsp_data
);
   import lkcc_pkg::*;

   localparam int SLOT_W = $clog2(CACHE_SLOTS);
   localparam int EXT_W  = (SLOT_W > SLOT_OUT_W) ? SLOT_W : SLOT_OUT_W;

   logic              enable_ff;
   req_type           key_ff;
   logic [SLOT_W-1:0] addr_ff;
   logic              cmp_vld_ff;
   logic [SLOT_W-1:0] cmp_idx_ff;
   logic              used_ff [CACHE_SLOTS];
   logic [SLOT_W-1:0] rank_ff [CACHE_SLOTS];
   logic              used_in [CACHE_SLOTS];
   logic [SLOT_W-1:0] rank_in [CACHE_SLOTS];
   logic              found_ff;
   logic [SLOT_W-1:0] hit_idx_ff;
   logic [SLOT_W-1:0] hit_rank_ff;
   logic [SLOT_W-1:0] vic_idx_ff;
   logic [SLOT_W-1:0] vic_rank_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;
   rsp_type           rsp_in;

   logic [KEY_W-1:0]  rd_data;
   logic              match;
   logic [SLOT_W-1:0] cmp_rank;
   logic [SLOT_W-1:0] sel_idx;
   logic [SLOT_W-1:0] sel_rank;
   logic [EXT_W-1:0]  sel_ext;

   lkcc_ram #(
      .WIDTH (KEY_W),
      .DEPTH (CACHE_SLOTS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && !found_ff),
      .wr_addr (vic_idx_ff),
      .wr_data (key_ff),
      .rd_en   (cmd.scan),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign match    = used_ff[cmp_idx_ff] && (rd_data == KEY_W'(key_ff));
   assign cmp_rank = rank_ff[cmp_idx_ff];
   assign sel_idx  = found_ff ? hit_idx_ff : vic_idx_ff;
   assign sel_rank = found_ff ? hit_rank_ff : vic_rank_ff;
   assign sel_ext  = EXT_W'(sel_idx);

   assign status.enable    = enable_ff;
   assign status.last_addr = (addr_ff == SLOT_W'(CACHE_SLOTS - 1));

   always_comb begin
      for (int i = 0; i < CACHE_SLOTS; i++) begin
         used_in[i] = used_ff[i];
         rank_in[i] = rank_ff[i];
         if (cmd.commit) begin
            if (SLOT_W'(i) == sel_idx) begin
               used_in[i] = 1'b1;
               rank_in[i] = '0;
            end else if (rank_ff[i] < sel_rank) begin
               rank_in[i] = rank_ff[i] + SLOT_W'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_in = '0;
      if (cmd.commit) begin
         rsp_in.hit        = found_ff;
         rsp_in.slot       = sel_ext[SLOT_OUT_W-1:0];
         rsp_in.slot_valid = 1'b1;
         rsp_in.evicted    = !found_ff && used_ff[vic_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            used_ff[i] <= 1'b0;
            rank_ff[i] <= SLOT_W'(i);
         end
      end else begin
         if (csr_valid) begin
            enable_ff <= csr_data;
         end
         cmp_vld_ff   <= cmd.scan;
         rsp_valid_ff <= cmd.commit || cmd.reject;
         for (int i = 0; i < CACHE_SLOTS; i++) begin
            used_ff[i] <= used_in[i];
            rank_ff[i] <= rank_in[i];
         end
         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (cmp_vld_ff && match && (!found_ff || cmp_rank < hit_rank_ff)) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff  <= req_data;
         addr_ff <= '0;
      end else if (cmd.scan) begin
         addr_ff <= addr_ff + SLOT_W'(1);
      end
      cmp_idx_ff <= addr_ff;
      if (cmp_vld_ff) begin
         if (match && (!found_ff || cmp_rank < hit_rank_ff)) begin
            hit_idx_ff  <= cmp_idx_ff;
            hit_rank_ff <= cmp_rank;
         end
         if ((cmp_idx_ff == '0) || (cmp_rank > vic_rank_ff)) begin
            vic_idx_ff  <= cmp_idx_ff;
            vic_rank_ff <= cmp_rank;
         end
      end
      if (cmd.commit || cmd.reject) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/lru_keyed_config_cache_top.sv */
// Enabled lookup: key RAM scan of all slots, WAIT, COMMIT; result strobe registered from COMMIT.
// A new start is taken only when the controller is back in idle; busy is high until then.
// Disabled lookup: result strobe in the cycle after start; a new start is taken in that cycle.
// Synchronous reset empties all slots, orders recency by slot index and disables the cache.
// The receiver cannot stall; each result is flagged by rsp_valid for exactly one cycle.
module lru_keyed_config_cache_top #(
   parameter int CACHE_SLOTS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  lkcc_pkg::req_type req_data,
   output logic              rsp_valid,
   output lkcc_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import lkcc_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   lkcc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   lkcc_dpath #(
      .CACHE_SLOTS (CACHE_SLOTS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/lkcc_checker.sv */
// Port-level checker for the keyed LRU cache, bound to the top level.
// Depends on lkcc_pkg and lru_keyed_config_cache_top.
module lkcc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input lkcc_pkg::rsp_type rsp_data
);
   import lkcc_pkg::*;

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.slot_valid) |->
         (!rsp_data.hit && !rsp_data.evicted && rsp_data.slot == '0))
      else $error("Disabled transaction reported a nonzero field.");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hit) |-> (rsp_data.slot_valid && !rsp_data.evicted))
      else $error("Hit transaction reported an eviction.");

   a_start_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("Accepted transaction neither started nor responded.");

   a_done_response: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("Lookup finished without a response.");

endmodule

bind lru_keyed_config_cache_top lkcc_checker u_lkcc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
